// ===== rtl/core/isort_pkg.sv =====
// Package for the ascending integer sorter.
// Holds the data widths, the default depth, the cell link and control types
// and the sequencer state type. It depends on nothing.
`default_nettype none

package isort_pkg;

  localparam int VALUE_W        = 32;
  localparam int SORT_DEPTH_DEF = 64;

  typedef struct packed {
    logic               valid;
    logic               gt;
    logic [VALUE_W-1:0] value;
  } isort_link_t;

  typedef struct packed {
    logic insert;
    logic shift;
  } isort_ctrl_t;

  typedef enum logic {
    ST_FILL,
    ST_DRAIN
  } isort_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/integer_sorter_ascending_top.sv =====
// Top level of the ascending integer sorter: a chain of isort_cell instances
// and the fill/drain sequencer. Depends on isort_pkg and isort_cell.
//
// The block takes one signed value per beat, one beat per cycle while
// in_stall is low, and keeps up to SORT_DEPTH of them in ascending order in
// a row of cells; each new value is placed by all cells at once in the cycle
// it arrives. Values that arrive when the row is full are dropped. The beat
// that carries in_final_item is stored like any other and then the row drains
// from its low end, smallest value first, one result beat per cycle that the
// output is not stalled, with out_end_of_run on the largest; in_stall stays
// high while the row drains.
`default_nettype none

module integer_sorter_ascending_top
  import isort_pkg::*;
#(
  parameter int SORT_DEPTH = SORT_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [VALUE_W-1:0] in_value,
  input  wire logic               in_final_item,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [VALUE_W-1:0]      out_sorted_value,
  output logic                    out_end_of_run
);

  isort_state_t state_r;
  isort_state_t state_nxt;
  isort_ctrl_t  ctrl;
  isort_link_t  links [0:SORT_DEPTH+1];
  logic         in_accept;
  logic         out_accept;

  assign links[0].valid         = 1'b1;
  assign links[0].gt            = 1'b0;
  assign links[0].value         = '0;
  assign links[SORT_DEPTH+1].valid = 1'b0;
  assign links[SORT_DEPTH+1].gt    = 1'b0;
  assign links[SORT_DEPTH+1].value = '0;

  assign in_accept  = in_valid && !in_stall;
  assign out_accept = out_valid && !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_FILL: begin
        if (in_accept && in_final_item) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_accept && !links[2].valid) begin
          state_nxt = ST_FILL;
        end
      end
      default: state_nxt = ST_FILL;
    endcase
  end

  always_comb begin
    in_stall    = 1'b0;
    out_valid   = 1'b0;
    ctrl.insert = 1'b0;
    ctrl.shift  = 1'b0;
    unique case (state_r)
      ST_FILL: begin
        ctrl.insert = in_accept && !links[SORT_DEPTH].valid;
      end
      ST_DRAIN: begin
        in_stall   = 1'b1;
        out_valid  = links[1].valid;
        ctrl.shift = out_accept;
      end
      default: in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_FILL;
    end else begin
      state_r <= state_nxt;
    end
  end

  for (genvar i = 1; i <= SORT_DEPTH; i++) begin : g_cell
    isort_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .new_value  (in_value),
      .left_link  (links[i-1]),
      .right_link (links[i+1]),
      .own_link   (links[i])
    );
  end

  assign out_sorted_value = links[1].value;
  assign out_end_of_run   = !links[2].valid;

endmodule

`default_nettype wire

// ===== rtl/core/isort_cell.sv =====
// One cell of the insertion chain: holds a single value and its valid flag.
// Depends on isort_pkg for the link and control types.
// It talks only to its left and right neighbors and to the broadcast value and control.
`default_nettype none

module isort_cell
  import isort_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire isort_ctrl_t        ctrl,
  input  wire logic [VALUE_W-1:0] new_value,
  input  wire isort_link_t        left_link,
  input  wire isort_link_t        right_link,
  output isort_link_t             own_link
);

  logic               valid_r;
  logic               valid_nxt;
  logic [VALUE_W-1:0] value_r;
  logic [VALUE_W-1:0] value_nxt;
  logic               gt;

  assign gt = !valid_r || ($signed(value_r) > $signed(new_value));

  always_comb begin
    valid_nxt = valid_r;
    value_nxt = value_r;
    priority if (ctrl.shift) begin
      valid_nxt = right_link.valid;
      value_nxt = right_link.value;
    end else if (ctrl.insert) begin
      valid_nxt = valid_r || left_link.valid;
      if (gt) begin
        value_nxt = left_link.gt ? left_link.value : new_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign own_link.valid = valid_r;
  assign own_link.gt    = gt;
  assign own_link.value = value_r;

endmodule

`default_nettype wire
